[rtl/core/f2i_pkg.sv]
// Package: shared types and constants for the float to int converter.
`timescale 1ns / 1ps
package f2i_pkg;
  localparam logic [7:0] EXP_ALL_ONES = 8'hFF;
  localparam logic [7:0] EXP_OVERFLOW = 8'd158;
  localparam logic [7:0] EXP_WHOLE    = 8'd150;
  localparam logic [7:0] EXP_HALF     = 8'd126;
  localparam logic [31:0] INT_MAX_PAT = 32'h7FFF_FFFF;
  localparam logic [31:0] INT_MIN_PAT = 32'h8000_0000;

  // Stage 1 -> 2: decoded operand and shift plan
  typedef struct packed {
    logic        neg;
    logic        bad;
    logic        zero;
    logic        left;
    logic [4:0]  shamt;
    logic [23:0] mant;
  } f2i_dec_t;

  // Stage 2 -> 3: aligned magnitude with rounding bits
  typedef struct packed {
    logic        neg;
    logic        bad;
    logic [31:0] mag;
    logic        round_bit;
    logic        sticky;
  } f2i_aln_t;
endpackage

[rtl/core/f2i_if.sv]
// Interfaces: input request channel and result channel.
`timescale 1ns / 1ps
interface f2i_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] float_bits;
  modport source (output valid, output float_bits, input ready);
  modport sink (input valid, input float_bits, output ready);
endinterface

interface f2i_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] int_value;
  logic               invalid;
  modport source (output valid, output int_value, output invalid, input ready);
  modport sink (input valid, input int_value, input invalid, output ready);
endinterface

[rtl/core/f2i_decode.sv]
// Decode stage: classify the operand and work out the alignment shift.
`timescale 1ns / 1ps
module f2i_decode (
  input  logic              [31:0] float_bits,
  output f2i_pkg::f2i_dec_t        dec
);
  logic [7:0] expo;
  logic [22:0] frac;
  logic neg;
  logic [7:0] rdiff;
  logic [7:0] ldiff;

  assign neg   = float_bits[31];
  assign expo  = float_bits[30:23];
  assign frac  = float_bits[22:0];
  assign rdiff = f2i_pkg::EXP_WHOLE - expo;
  assign ldiff = expo - f2i_pkg::EXP_WHOLE;

  always_comb begin
    dec.neg  = neg;
    dec.mant = {1'b1, frac};
    dec.bad  = 1'b0;
    dec.zero = 1'b0;
    dec.left = 1'b0;
    dec.shamt = 5'd0;
    if (expo == f2i_pkg::EXP_ALL_ONES) begin
      dec.bad = 1'b1;
    end else if (expo >= f2i_pkg::EXP_OVERFLOW) begin
      // only exactly -2^31 fits; it flows through as 1 << 31 below
      dec.bad = !(neg && expo == f2i_pkg::EXP_OVERFLOW && frac == 23'd0);
      dec.left = 1'b1;
      dec.shamt = 5'd8;
    end else if (expo < f2i_pkg::EXP_HALF) begin
      dec.zero = 1'b1; // below one half, zero or denormal
    end else if (expo >= f2i_pkg::EXP_WHOLE) begin
      dec.left = 1'b1;
      dec.shamt = ldiff[4:0];
    end else begin
      dec.shamt = rdiff[4:0]; // 1..24
    end
  end
endmodule

[rtl/core/f2i_align.sv]
// Align stage: shift the mantissa and collect round and sticky bits.
`timescale 1ns / 1ps
module f2i_align (
  input  f2i_pkg::f2i_dec_t dec,
  output f2i_pkg::f2i_aln_t aln
);
  logic [55:0] wide;
  logic [55:0] shr;
  logic [31:0] shl;

  assign wide = {8'd0, dec.mant, 24'd0};
  assign shr  = wide >> dec.shamt;
  assign shl  = {8'd0, dec.mant} << dec.shamt;

  always_comb begin
    aln.neg = dec.neg;
    aln.bad = dec.bad;
    aln.mag = 32'd0;
    aln.round_bit = 1'b0;
    aln.sticky = 1'b0;
    if (dec.zero || dec.bad) begin
      aln.mag = 32'd0;
    end else if (dec.left) begin
      // -2^31 keeps bit 31 here; negation below leaves it as INT_MIN
      aln.mag = shl;
    end else begin
      aln.mag = shr[55:24];
      aln.round_bit = shr[23];
      aln.sticky = |shr[22:0];
    end
  end
endmodule

[rtl/core/f2i_round.sv]
// Round stage: nearest-even increment, sign and saturation.
`timescale 1ns / 1ps
module f2i_round (
  input  f2i_pkg::f2i_aln_t aln,
  output logic       [31:0] int_value,
  output logic              invalid
);
  logic        inc;
  logic [31:0] mag32;

  assign inc   = aln.round_bit && (aln.sticky || aln.mag[0]);
  assign mag32 = aln.mag + {31'd0, inc};

  always_comb begin
    invalid = aln.bad;
    if (aln.bad) begin
      int_value = aln.neg ? f2i_pkg::INT_MIN_PAT : f2i_pkg::INT_MAX_PAT;
    end else if (aln.neg) begin
      int_value = 32'd0 - mag32;
    end else begin
      int_value = mag32;
    end
  end
endmodule

[rtl/core/float_to_int_converter.sv]
// Top level: pipelined single-precision float to int32 converter.
`timescale 1ns / 1ps
// Converts an IEEE-754 single to a signed 32-bit integer, round to nearest
// even. Three register stages (decode, align, round) plus the output
// register; a request moves through them in order, and one request is
// taken every cycle while the output is not stalled.
// The pipeline advances as a whole whenever the output register is empty or
// being drained; back-pressure stalls every stage together, losing nothing.
// NaN, infinity and magnitudes of 2^31 and above (except exactly -2^31)
// saturate by sign and set invalid.
module float_to_int_converter (
  input  logic      clk,
  input  logic      rst_n,
  f2i_in_if.sink    in_ch,
  f2i_out_if.source out_ch
);
  logic                  advance;
  logic [31:0]           in_bits_r;
  logic                  v1_r, v2_r, v3_r, vo_r;
  f2i_pkg::f2i_dec_t     dec, dec_r;
  f2i_pkg::f2i_aln_t     aln, aln_r;
  logic [31:0]           res_value;
  logic                  res_invalid;
  logic [31:0]           out_value_r;
  logic                  out_invalid_r;

  // whole pipe moves when the result slot is free or being taken
  assign advance      = !vo_r || out_ch.ready;
  assign in_ch.ready  = advance;

  f2i_decode u_dec (.float_bits(in_bits_r), .dec(dec));
  f2i_align  u_aln (.dec(dec_r), .aln(aln));
  f2i_round  u_rnd (.aln(aln_r), .int_value(res_value), .invalid(res_invalid));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (advance) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      in_bits_r     <= in_ch.float_bits;
      dec_r         <= dec;
      aln_r         <= aln;
      out_value_r   <= res_value;
      out_invalid_r <= res_invalid;
    end
  end

  assign out_ch.valid     = vo_r;
  assign out_ch.int_value = out_value_r;
  assign out_ch.invalid   = out_invalid_r;
endmodule

[rtl/core/f2i_checker.sv]
// Checker: port-level properties of the converter, bound to the top level.
`timescale 1ns / 1ps
module f2i_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_int_value,
  input logic        out_invalid
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_int_value))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |->
      (out_int_value == 32'h7FFF_FFFF || out_int_value == 32'h8000_0000))
    else $error("invalid result not saturated");

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready ##1 out_ready
      |=> out_valid)
    else $error("result missing after pipeline latency");
endmodule

bind float_to_int_converter f2i_checker u_f2i_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_int_value(out_ch.int_value),
  .out_invalid(out_ch.invalid)
);
